// ----- hdl/ftc_pkg.sv -----
// ----------------------------------------------------------------------------
// Force-to-torque controller package
// Shared types, register indexes, opcodes, fixed-point constants and the
// quarter-wave sine table used by the force-to-torque current controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ftc_pkg;

    // Field widths and payload types
    localparam int FORCE_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [FORCE_W-1:0] q78_t;
    typedef logic signed [15:0]        angle_t;
    typedef logic signed [15:0]        iq_t;
    typedef logic signed [15:0]        sin_q14_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

    // Opcodes of an input item
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes
    localparam cfg_index_t CFG_TARE_FORCE      = 3'd0;
    localparam cfg_index_t CFG_ARM_MASS        = 3'd1;
    localparam cfg_index_t CFG_GRAVITY_LENGTH  = 3'd2;
    localparam cfg_index_t CFG_INV_TORQUE_GAIN = 3'd3;
    localparam cfg_index_t CFG_MAX_CURRENT     = 3'd4;

    // Configuration reset values
    localparam logic signed [15:0] TARE_FORCE_RST  = 16'sd0;
    localparam logic [14:0]        ARM_MASS_RST    = 15'd256;
    localparam logic [15:0]        GRAVITY_LEN_RST = 16'd2512;
    localparam logic [15:0]        INV_GAIN_RST    = 16'd256;
    localparam logic [14:0]        MAX_CURRENT_RST = 15'd2000;

    // Fixed-point constants
    localparam int ACCEPT_BAND = 256;     // 1 kg in Q7.8
    localparam int STEP_LIMIT  = 128;     // 0.5 kg in Q7.8
    localparam int BACKOFF     = 77;      // 0.3 kg in Q7.8
    localparam int ONE_Q14     = 16384;
    localparam int ROUND_Q14   = 8192;
    localparam int ANGLE_MOD   = 360;
    localparam int ANGLE_BIAS  = 33120;   // 92 turns, makes any angle positive
    localparam int IQ_SHIFT    = 38;
    localparam int Q78_MAX     = 32767;
    localparam int Q78_MIN     = -32768;

    // Shift-add multiplier geometry
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 48;

    // Sine in Q1.14 over 0..90 degrees
    localparam logic [14:0] SIN_TABLE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    // Sine of an angle already reduced to 0..359 degrees, mirrored per quadrant
    function automatic sin_q14_t sin_lookup(input logic [8:0] deg);
        logic [6:0]  idx;
        logic        neg;
        logic [15:0] mag;
        priority if (deg <= 9'd90)
        begin
            idx = deg[6:0];
            neg = 1'b0;
        end
        else if (deg <= 9'd180)
        begin
            idx = 7'(9'd180 - deg);
            neg = 1'b0;
        end
        else if (deg <= 9'd270)
        begin
            idx = 7'(deg - 9'd180);
            neg = 1'b1;
        end
        else
        begin
            idx = 7'(9'd360 - deg);
            neg = 1'b1;
        end
        mag = {1'b0, SIN_TABLE[idx]};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ftc_window.sv -----
// ----------------------------------------------------------------------------
// Force window
// Jump gate on incoming force samples and a ring window of held values with
// a running sum that is kept up to date on every sample item.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_window #(
    parameter int WINDOW_LEN = 15,
    parameter int SUM_W      = 20
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    input  wire ftc_pkg::q78_t      sample,
    output logic signed [SUM_W-1:0] window_sum
);
    import ftc_pkg::*;

    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int DIFF_W = FORCE_W + 1;
    localparam logic signed [DIFF_W-1:0] BAND_HI = DIFF_W'(ACCEPT_BAND);
    localparam logic signed [DIFF_W-1:0] BAND_LO = -BAND_HI;

    q78_t                     accepted_reg;
    q78_t                     window_reg [WINDOW_LEN];
    logic [IDX_W-1:0]         idx_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic signed [DIFF_W-1:0] diff;
    q78_t                     accepted_next;
    logic [IDX_W-1:0]         idx_next;
    logic signed [SUM_W-1:0]  sum_next;

    // A sample within the band replaces the held value, otherwise it is held
    always_comb
    begin
        diff          = DIFF_W'(sample) - DIFF_W'(accepted_reg);
        accepted_next = (diff > BAND_LO && diff < BAND_HI) ? sample : accepted_reg;
        sum_next      = sum_reg + SUM_W'(accepted_next) - SUM_W'(window_reg[idx_reg]);
        if (idx_reg == IDX_W'(WINDOW_LEN - 1))
            idx_next = '0;
        else
            idx_next = idx_reg + 1'b1;
    end

    // Window entries, write pointer and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg <= '0;
            idx_reg      <= '0;
            sum_reg      <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
                window_reg[i] <= '0;
        end
        else if (sample_valid)
        begin
            accepted_reg        <= accepted_next;
            idx_reg             <= idx_next;
            sum_reg             <= sum_next;
            window_reg[idx_reg] <= accepted_next;
        end
    end

    assign window_sum = sum_reg;

endmodule

`default_nettype wire

// ----- hdl/ftc_divider.sv -----
// ----------------------------------------------------------------------------
// Serial divider by a constant
// Restoring division of an unsigned dividend by a fixed divisor, one
// quotient bit per cycle, giving both quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_divider #(
    parameter int N_W     = 16,
    parameter int DIVISOR = 360
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [N_W-1:0]              dividend,
    output logic                             done,
    output logic [N_W-1:0]                   quotient,
    output logic [$clog2(DIVISOR)-1:0]       remainder
);
    localparam int R_W   = $clog2(DIVISOR);
    localparam int CNT_W = $clog2(N_W);
    localparam logic [R_W:0] DIV_K = (R_W + 1)'(DIVISOR);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   q_reg;
    logic [R_W-1:0]   r_reg;

    logic [R_W:0]     trial;
    logic             fits;
    logic             last;

    // One restoring step: bring down the next bit and subtract if it fits
    always_comb
    begin
        trial = {r_reg, q_reg[N_W-1]};
        fits  = (trial >= DIV_K);
        last  = (cnt_reg == CNT_W'(N_W - 1));
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Quotient and partial remainder shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[N_W-2:0], fits};
            r_reg <= fits ? R_W'(trial - DIV_K) : trial[R_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

// ----- hdl/ftc_serial_mul.sv -----
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed shift-add multiplier that takes one bit of the serial operand per
// cycle; the last bit carries negative weight.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_serial_mul #(
    parameter int A_W = 18,
    parameter int B_W = 48
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [A_W-1:0]     a,
    input  wire logic signed [B_W-1:0]     b,
    output logic                           done,
    output logic signed [A_W+B_W-1:0]      product
);
    localparam int CNT_W = $clog2(B_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic signed [A_W-1:0] a_reg;
    logic signed [A_W:0]   hi_reg;
    logic [B_W-1:0]        lo_reg;

    logic                  last;
    logic signed [A_W:0]   a_ext;
    logic signed [A_W:0]   addend;
    logic signed [A_W:0]   acc;

    // Add or, on the sign bit, subtract the multiplicand
    always_comb
    begin
        last  = (cnt_reg == CNT_W'(B_W - 1));
        a_ext = (A_W + 1)'(a_reg);
        if (!lo_reg[0])
            addend = '0;
        else if (last)
            addend = -a_ext;
        else
            addend = a_ext;
        acc = hi_reg + addend;
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Partial product shifts right one bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= acc >>> 1;
            lo_reg <= {acc[0], lo_reg[B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = $signed({hi_reg[A_W-1:0], lo_reg});

endmodule

`default_nettype wire

// ----- hdl/force_to_torque_current_controller_top.sv -----
// ----------------------------------------------------------------------------
// Force-to-torque current controller
// A force sample item is absorbed while the sequencer is idle and samples may follow back to back.
// A control tick item runs the angle and average dividers (one bit per cycle), then
// four passes of the shared shift-add multiplier; the next item is taken once the
// result is registered, or later still while an earlier result waits. One tick is
// in work at a time.
// Asynchronous active-low reset clears the window, state and registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module force_to_torque_current_controller_top #(
    parameter int WINDOW_LEN = 15
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Command channel
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire logic                opcode,
    input  wire ftc_pkg::q78_t       force_sample,
    input  wire ftc_pkg::angle_t     angle_deg,
    // Result channel
    output logic                     res_valid,
    input  wire logic                res_ready,
    output ftc_pkg::iq_t             iq_command,
    output ftc_pkg::q78_t            limited_effort,
    // Configuration write port
    input  wire logic                cfg_we,
    input  wire ftc_pkg::cfg_index_t cfg_index,
    input  wire ftc_pkg::cfg_data_t  cfg_data
);
    import ftc_pkg::*;

    localparam int SUM_W   = FORCE_W + $clog2(WINDOW_LEN + 1);
    localparam int NUM_W   = $clog2(2 * WINDOW_LEN) + 17;
    localparam int ANG_W   = 17;
    localparam int ANG_R_W = $clog2(ANGLE_MOD);
    localparam int P_W     = MUL_A_W + MUL_B_W;
    localparam int WIDE_W  = 21;
    localparam int IQ_W    = 26;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_TARE,
        ST_MUL_ARM,
        ST_MUL_GL,
        ST_MUL_GAIN,
        ST_OUT
    } state_t;

    // Saturate a widened value to Q7.8
    function automatic q78_t sat_q78(input logic signed [WIDE_W-1:0] v);
        if (v > WIDE_W'(Q78_MAX))
            return FORCE_W'(Q78_MAX);
        else if (v < WIDE_W'(Q78_MIN))
            return FORCE_W'(Q78_MIN);
        else
            return v[FORCE_W-1:0];
    endfunction

    // Configuration registers
    logic signed [15:0] tare_reg;
    logic [14:0]        arm_mass_reg;
    logic [15:0]        gl_reg;
    logic [15:0]        inv_gain_reg;
    logic [14:0]        max_current_reg;

    // Sequencer and datapath registers
    state_t                     state_reg;
    logic                       go_reg;
    sin_q14_t                   s_reg;
    q78_t                       effort_reg;
    q78_t                       prev_reg;
    logic signed [31:0]         inner_reg;
    logic signed [MUL_B_W-1:0]  torque_reg;
    iq_t                        iq_reg;
    logic                       res_valid_reg;
    iq_t                        res_iq_reg;
    q78_t                       res_effort_reg;

    // Handshake decode
    logic sample_accept;
    logic tick_accept;

    // Window and divider signals
    logic signed [SUM_W-1:0] window_sum;
    logic signed [NUM_W:0]   sum_ext;
    logic signed [NUM_W:0]   avg_num_wide;
    logic [NUM_W-1:0]        avg_num;
    logic signed [16:0]      angle_wide;
    logic                    div_ang_done;
    logic                    div_avg_done;
    logic [ANG_W-1:0]        ang_q_unused;
    logic [ANG_R_W-1:0]      ang_rem;
    logic [NUM_W-1:0]        avg_q;
    logic [$clog2(2 * WINDOW_LEN)-1:0] avg_rem_unused;

    // Multiplier signals
    logic                      mul_done;
    logic                      mul_ready;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [P_W-1:0]     mul_p;
    logic [16:0]               one_minus_sin;

    // Tick arithmetic
    logic signed [33:0]       tare_round;
    logic signed [19:0]       tare_term;
    q78_t                     avg;
    logic signed [WIDE_W-1:0] cur_wide;
    q78_t                     cur;
    logic signed [16:0]       step;
    q78_t                     effort_next;
    logic signed [31:0]       inner_next;
    logic signed [63:0]       prod;
    logic signed [IQ_W-1:0]   iq_trunc;
    logic signed [IQ_W-1:0]   lim;
    iq_t                      iq_next;

    assign cmd_ready     = (state_reg == ST_IDLE);
    assign sample_accept = cmd_valid && cmd_ready && (opcode == OP_SAMPLE);
    assign tick_accept   = cmd_valid && cmd_ready && (opcode == OP_TICK);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg        <= TARE_FORCE_RST;
            arm_mass_reg    <= ARM_MASS_RST;
            gl_reg          <= GRAVITY_LEN_RST;
            inv_gain_reg    <= INV_GAIN_RST;
            max_current_reg <= MAX_CURRENT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARE_FORCE:      tare_reg        <= $signed(cfg_data);
                CFG_ARM_MASS:        arm_mass_reg    <= cfg_data[14:0];
                CFG_GRAVITY_LENGTH:  gl_reg          <= cfg_data;
                CFG_INV_TORQUE_GAIN: inv_gain_reg    <= cfg_data;
                CFG_MAX_CURRENT:     max_current_reg <= cfg_data[14:0];
                default:             ;
            endcase
        end
    end

    // Sample gate and ring window
    ftc_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_accept),
        .sample       (force_sample),
        .window_sum   (window_sum)
    );

    // Dividends: biased angle and the rounded, biased average numerator
    always_comb
    begin
        angle_wide   = 17'(angle_deg) + 17'(ANGLE_BIAS);
        sum_ext      = (NUM_W + 1)'(window_sum);
        avg_num_wide = sum_ext + sum_ext + (NUM_W + 1)'(WINDOW_LEN)
                     + (NUM_W + 1)'(2 * WINDOW_LEN * 65536);
        avg_num      = avg_num_wide[NUM_W-1:0];
    end

    ftc_divider #(
        .N_W     (ANG_W),
        .DIVISOR (ANGLE_MOD)
    ) u_div_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (tick_accept),
        .dividend  (angle_wide[ANG_W-1:0]),
        .done      (div_ang_done),
        .quotient  (ang_q_unused),
        .remainder (ang_rem)
    );

    ftc_divider #(
        .N_W     (NUM_W),
        .DIVISOR (2 * WINDOW_LEN)
    ) u_div_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (tick_accept),
        .dividend  (avg_num),
        .done      (div_avg_done),
        .quotient  (avg_q),
        .remainder (avg_rem_unused)
    );

    // Multiplier operand selection per pass
    always_comb
    begin
        one_minus_sin = 17'(ONE_Q14) - 17'(s_reg);
        unique case (state_reg)
            ST_MUL_TARE:
            begin
                mul_a = $signed({1'b0, one_minus_sin});
                mul_b = MUL_B_W'(tare_reg);
            end
            ST_MUL_ARM:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = $signed(MUL_B_W'(arm_mass_reg));
            end
            ST_MUL_GL:
            begin
                mul_a = $signed(MUL_A_W'(gl_reg));
                mul_b = MUL_B_W'(inner_reg);
            end
            ST_MUL_GAIN:
            begin
                mul_a = $signed(MUL_A_W'(inv_gain_reg));
                mul_b = torque_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ftc_serial_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go_reg),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign mul_ready = mul_done && !go_reg;

    // Tare removal, step limit and the current command
    always_comb
    begin
        tare_round = $signed(mul_p[33:0]) + 34'(ROUND_Q14);
        tare_term  = tare_round[33:14];
        avg        = $signed(avg_q[FORCE_W-1:0]);
        cur_wide   = WIDE_W'(avg) - WIDE_W'(tare_term);
        cur        = sat_q78(cur_wide);
        step       = 17'(cur) - 17'(prev_reg);
        if (step > -17'(STEP_LIMIT) && step < 17'(STEP_LIMIT))
            effort_next = cur;
        else if (step >= 17'(STEP_LIMIT))
            effort_next = sat_q78(WIDE_W'(prev_reg) - WIDE_W'(BACKOFF));
        else
            effort_next = sat_q78(WIDE_W'(prev_reg) + WIDE_W'(BACKOFF));

        inner_next = (32'(effort_reg) <<< 14) + $signed(mul_p[31:0]);

        // Truncate toward zero, then clamp keeping the sign
        prod     = mul_p[63:0];
        iq_trunc = $signed(prod[63:IQ_SHIFT])
                 + IQ_W'(prod[63] && (prod[IQ_SHIFT-1:0] != '0));
        lim      = IQ_W'(max_current_reg);
        if (iq_trunc > lim)
            iq_next = 16'(lim);
        else if (iq_trunc < -lim)
            iq_next = 16'(-lim);
        else
            iq_next = iq_trunc[15:0];
    end

    // Tick sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            go_reg         <= 1'b0;
            s_reg          <= '0;
            effort_reg     <= '0;
            prev_reg       <= '0;
            inner_reg      <= '0;
            torque_reg     <= '0;
            iq_reg         <= '0;
            res_valid_reg  <= 1'b0;
            res_iq_reg     <= '0;
            res_effort_reg <= '0;
        end
        else
        begin
            // A multiplier pass starts after the dividers and after each pass
            // but the last.
            go_reg <= ((state_reg == ST_DIV) && div_ang_done && div_avg_done)
                   || (mul_ready && ((state_reg == ST_MUL_TARE)
                                  || (state_reg == ST_MUL_ARM)
                                  || (state_reg == ST_MUL_GL)));

            // The result register fills from the last state and empties on
            // acceptance.
            if ((state_reg == ST_OUT) && (!res_valid_reg || res_ready))
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (tick_accept)
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_ang_done && div_avg_done)
                    begin
                        s_reg     <= sin_lookup(ang_rem);
                        state_reg <= ST_MUL_TARE;
                    end
                end
                ST_MUL_TARE:
                begin
                    if (mul_ready)
                    begin
                        effort_reg <= effort_next;
                        prev_reg   <= cur;
                        state_reg  <= ST_MUL_ARM;
                    end
                end
                ST_MUL_ARM:
                begin
                    if (mul_ready)
                    begin
                        inner_reg <= inner_next;
                        state_reg <= ST_MUL_GL;
                    end
                end
                ST_MUL_GL:
                begin
                    if (mul_ready)
                    begin
                        torque_reg <= mul_p[MUL_B_W-1:0];
                        state_reg  <= ST_MUL_GAIN;
                    end
                end
                ST_MUL_GAIN:
                begin
                    if (mul_ready)
                    begin
                        iq_reg    <= iq_next;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_iq_reg     <= iq_reg;
                        res_effort_reg <= effort_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid      = res_valid_reg;
    assign iq_command     = res_iq_reg;
    assign limited_effort = res_effort_reg;

endmodule

`default_nettype wire

// ----- hdl/ftc_checker.sv -----
// ----------------------------------------------------------------------------
// Force-to-torque controller checker
// Port-level assertions on item flow of the controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          cmd_valid,
    input wire logic          cmd_ready,
    input wire logic          opcode,
    input wire logic          res_valid,
    input wire logic          res_ready,
    input wire ftc_pkg::iq_t  iq_command,
    input wire ftc_pkg::q78_t limited_effort
);
    import ftc_pkg::*;

    // A tick occupies the datapath, so the command side stalls next cycle.
    a_tick_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && opcode == OP_TICK) |=> !cmd_ready)
        else $error("command side still ready after a tick item");

    // After a sample item the command side is ready again in the next cycle.
    a_sample_single: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && opcode == OP_SAMPLE) |=> cmd_ready)
        else $error("sample item did not complete in one cycle");

    // The clamp is symmetric, so the most negative code never appears.
    a_iq_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (iq_command != 16'sh8000))
        else $error("current command outside the symmetric limit");

    // A stalled result holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(iq_command) && $stable(limited_effort)))
        else $error("result item changed while stalled");

endmodule

bind force_to_torque_current_controller_top ftc_checker u_ftc_checker (.*);

`default_nettype wire
